// ===== rtl/cpid_pkg.sv =====
// cpid_pkg: shared types and constants for the clamped pid controller
// register index codes, request and form codes, configuration bundle
// no dependencies
package cpid_pkg;

  localparam int GAIN_W     = 32;
  localparam int LIMIT_W    = 16;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // queue depths between the parts
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORM_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_UPPER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LOWER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 3'd7;

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic FORM_POSITIONAL  = 1'b0;
  localparam logic FORM_INCREMENTAL = 1'b1;

  localparam logic signed [LIMIT_W-1:0] LIMIT_MAX = 16'sh7fff;
  localparam logic signed [LIMIT_W-1:0] LIMIT_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  kp_gain;
    logic signed [GAIN_W-1:0]  ki_gain;
    logic signed [GAIN_W-1:0]  kd_gain;
    logic                      form_select;
    logic signed [LIMIT_W-1:0] term_upper;
    logic signed [LIMIT_W-1:0] term_lower;
    logic signed [LIMIT_W-1:0] drive_upper;
    logic signed [LIMIT_W-1:0] drive_lower;
  } cfg_t;

endpackage

// ===== rtl/clamped_pid_controller.sv =====
// clamped_pid_controller: top level, configuration registers and the two queues
// depends on cpid_pkg, cpid_fifo, cpid_front, cpid_back
//
// One request word in, one drive word out, at up to one word per clock each
// way. A pushed word passes through the front, which files it into a four-entry
// queue, and the back runs it through multiply, term clamp, integral and
// accumulator stages (one register each) into an eight-entry result queue.
// The integral and the drive accumulator each close their loop through a
// single add and clamp, which sets the one-word-a-cycle rate. full rises only
// when results are left unpopped and both queues fill. A clear request zeroes
// the error history and both accumulators and returns a drive of zero;
// configuration writes take effect at once and are meant for when no word is
// in flight.
module clamped_pid_controller #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]        target_value,
  input  logic signed [SAMPLE_WIDTH-1:0]        measured_value,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [cpid_pkg::DRIVE_W-1:0]   drive_value,
  input  logic                                  cfg_write,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cpid_pkg::*;

  localparam int ERR_W   = SAMPLE_WIDTH + 1;
  localparam int D1_W    = SAMPLE_WIDTH + 2;
  localparam int D2_W    = SAMPLE_WIDTH + 3;
  localparam int ENTRY_W = 1 + D1_W + ERR_W + D2_W;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain     <= '0;
      cfg.ki_gain     <= '0;
      cfg.kd_gain     <= '0;
      cfg.form_select <= FORM_POSITIONAL;
      cfg.term_upper  <= LIMIT_MAX;
      cfg.term_lower  <= LIMIT_MIN;
      cfg.drive_upper <= LIMIT_MAX;
      cfg.drive_lower <= LIMIT_MIN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP_GAIN:     cfg.kp_gain     <= cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:     cfg.ki_gain     <= cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:     cfg.kd_gain     <= cfg_data[GAIN_W-1:0];
        REG_FORM_SELECT: cfg.form_select <= cfg_data[0];
        REG_TERM_UPPER:  cfg.term_upper  <= cfg_data[LIMIT_W-1:0];
        REG_TERM_LOWER:  cfg.term_lower  <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_UPPER: cfg.drive_upper <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_LOWER: cfg.drive_lower <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front to middle queue
  logic                    mid_full;
  logic                    mid_push;
  logic                    f_clear;
  logic signed [D1_W-1:0]  f_p_op;
  logic signed [ERR_W-1:0] f_i_op;
  logic signed [D2_W-1:0]  f_d_op;

  cpid_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .target_value   (target_value),
    .measured_value (measured_value),
    .form_select    (cfg.form_select),
    .queue_full     (mid_full),
    .queue_push     (mid_push),
    .q_clear        (f_clear),
    .q_p_op         (f_p_op),
    .q_i_op         (f_i_op),
    .q_d_op         (f_d_op)
  );

  logic [ENTRY_W-1:0]               mid_in;
  logic [ENTRY_W-1:0]               mid_out;
  logic                             mid_empty;
  logic                             mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0]   mid_level;

  assign mid_in = {f_clear, f_p_op, f_i_op, f_d_op};

  cpid_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .pop       (mid_pop),
    .pop_data  (mid_out),
    .full      (mid_full),
    .empty     (mid_empty),
    .level     (mid_level)
  );

  // entry layout: clear, p operand, i operand, d operand
  logic                    b_clear;
  logic signed [D1_W-1:0]  b_p_op;
  logic signed [ERR_W-1:0] b_i_op;
  logic signed [D2_W-1:0]  b_d_op;

  assign b_clear = mid_out[ENTRY_W-1] && (mid_level != '0);
  assign b_p_op  = mid_out[ENTRY_W-2 -: D1_W];
  assign b_i_op  = mid_out[D2_W +: ERR_W];
  assign b_d_op  = mid_out[D2_W-1:0];

  logic                     out_push;
  logic signed [DRIVE_W-1:0] out_drive;
  logic [OUT_LEVEL_W-1:0]   out_level;
  logic                     out_full;

  cpid_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (mid_empty),
    .q_clear   (b_clear),
    .q_p_op    (b_p_op),
    .q_i_op    (b_i_op),
    .q_d_op    (b_d_op),
    .q_pop     (mid_pop),
    .out_level (out_level),
    .out_push  (out_push),
    .out_drive (out_drive)
  );

  // credits in the back keep this queue from overflowing
  cpid_fifo #(
    .WIDTH (DRIVE_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push && !out_full),
    .push_data (out_drive),
    .pop       (pop),
    .pop_data  (drive_value),
    .full      (out_full),
    .empty     (empty),
    .level     (out_level)
  );

endmodule

// ===== rtl/cpid_fifo.sv =====
// cpid_fifo: small register queue with level output
// used between front and back and on the result side
// depends on nothing
module cpid_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 push_data,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 pop_data,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       level
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == LVL_W'(DEPTH));
  assign empty    = (count == '0);
  assign level    = count;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cpid_front.sv =====
// cpid_front: accepts request words, forms the error and its differences
// keeps the error history and picks the multiplier operands per form
// depends on cpid_pkg
module cpid_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic signed [SAMPLE_WIDTH-1:0] target_value,
  input  logic signed [SAMPLE_WIDTH-1:0] measured_value,
  input  logic                           form_select,
  input  logic                           queue_full,
  output logic                           queue_push,
  output logic                           q_clear,
  output logic signed [SAMPLE_WIDTH+1:0] q_p_op,
  output logic signed [SAMPLE_WIDTH:0]   q_i_op,
  output logic signed [SAMPLE_WIDTH+2:0] q_d_op
);
  import cpid_pkg::*;

  localparam int ERR_W = SAMPLE_WIDTH + 1;
  localparam int D1_W  = SAMPLE_WIDTH + 2;
  localparam int D2_W  = SAMPLE_WIDTH + 3;

  logic signed [ERR_W-1:0] prev_error;
  logic signed [ERR_W-1:0] prev_prev_error;
  logic signed [ERR_W-1:0] err;
  logic signed [D1_W-1:0]  diff1;
  logic signed [D2_W-1:0]  diff2;
  logic                    accept;

  assign err   = ERR_W'(target_value) - ERR_W'(measured_value);
  assign diff1 = D1_W'(err) - D1_W'(prev_error);
  // second difference: err - 2*prev + prev_prev
  assign diff2 = D2_W'(err) - (D2_W'(prev_error) <<< 1) + D2_W'(prev_prev_error);

  assign accept     = push && !queue_full;
  assign full       = queue_full;
  assign queue_push = accept;
  assign q_clear    = (req_type == REQ_CLEAR);
  assign q_i_op     = err;

  always_comb begin
    if (form_select == FORM_POSITIONAL) begin
      q_p_op = D1_W'(err);
      q_d_op = D2_W'(diff1);
    end else begin
      q_p_op = diff1;
      q_d_op = diff2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error      <= '0;
      prev_prev_error <= '0;
    end else if (accept) begin
      if (req_type == REQ_CLEAR) begin
        prev_error      <= '0;
        prev_prev_error <= '0;
      end else if (form_select == FORM_POSITIONAL) begin
        prev_error <= err;
      end else begin
        prev_prev_error <= prev_error;
        prev_error      <= err;
      end
    end
  end

endmodule

// ===== rtl/cpid_back.sv =====
// cpid_back: four-stage datapath: multiply, term clamp, integral, drive
// issues from the middle queue only when the result queue has room
// depends on cpid_pkg
module cpid_back #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cpid_pkg::cfg_t                          cfg,
  input  logic                                    q_empty,
  input  logic                                    q_clear,
  input  logic signed [SAMPLE_WIDTH+1:0]          q_p_op,
  input  logic signed [SAMPLE_WIDTH:0]            q_i_op,
  input  logic signed [SAMPLE_WIDTH+2:0]          q_d_op,
  output logic                                    q_pop,
  input  logic [cpid_pkg::OUT_LEVEL_W-1:0]        out_level,
  output logic                                    out_push,
  output logic signed [cpid_pkg::DRIVE_W-1:0]     out_drive
);
  import cpid_pkg::*;

  localparam int D2_W   = SAMPLE_WIDTH + 3;
  localparam int PROD_W = GAIN_W + D2_W;
  localparam int LIM_W  = LIMIT_W + FRAC_BITS;
  localparam int CMP_W  = ((PROD_W > LIM_W + 3) ? PROD_W : LIM_W + 3) + 1;
  localparam int CRD_W  = OUT_LEVEL_W + 1;

  function automatic logic signed [CMP_W-1:0] clamp_val(
    input logic signed [CMP_W-1:0] x,
    input logic signed [CMP_W-1:0] hi,
    input logic signed [CMP_W-1:0] lo
  );
    logic signed [CMP_W-1:0] r;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r;
  endfunction

  logic signed [LIM_W-1:0] thi, tlo, dhi, dlo;
  assign thi = {cfg.term_upper, {FRAC_BITS{1'b0}}};
  assign tlo = {cfg.term_lower, {FRAC_BITS{1'b0}}};
  assign dhi = {cfg.drive_upper, {FRAC_BITS{1'b0}}};
  assign dlo = {cfg.drive_lower, {FRAC_BITS{1'b0}}};

  // issue control: words in the pipe plus words queued must fit the result queue
  logic s1_v, s2_v, s3_v, s4_v;
  logic [CRD_W-1:0] committed;
  logic             issue;

  assign committed = CRD_W'(out_level) + CRD_W'(s1_v) + CRD_W'(s2_v)
                   + CRD_W'(s3_v) + CRD_W'(s4_v);
  assign issue     = !q_empty && (committed < CRD_W'(OUT_DEPTH));
  assign q_pop     = issue;

  // stage 1: products
  logic                     s1_clear;
  logic signed [PROD_W-1:0] s1_pprod, s1_iprod, s1_dprod;

  always_ff @(posedge clk) begin
    s1_clear <= q_clear;
    s1_pprod <= PROD_W'(cfg.kp_gain) * PROD_W'(q_p_op);
    s1_iprod <= PROD_W'(cfg.ki_gain) * PROD_W'(q_i_op);
    s1_dprod <= PROD_W'(cfg.kd_gain) * PROD_W'(q_d_op);
  end

  // stage 2: clamp p, i and d terms, pre-add the parts that do not need state
  logic signed [CMP_W-1:0]  p_full, i_full, d_full;
  logic signed [LIM_W-1:0]  p_c, i_c, d_c;
  logic                     s2_clear;
  logic signed [PROD_W-1:0] s2_iprod;
  logic signed [LIM_W-1:0]  s2_ic;
  logic signed [LIM_W:0]    s2_pd;
  logic signed [LIM_W+1:0]  s2_pid;

  assign p_full = clamp_val(CMP_W'(s1_pprod), CMP_W'(thi), CMP_W'(tlo));
  assign i_full = clamp_val(CMP_W'(s1_iprod), CMP_W'(thi), CMP_W'(tlo));
  assign d_full = clamp_val(CMP_W'(s1_dprod), CMP_W'(thi), CMP_W'(tlo));
  assign p_c    = p_full[LIM_W-1:0];
  assign i_c    = i_full[LIM_W-1:0];
  assign d_c    = d_full[LIM_W-1:0];

  always_ff @(posedge clk) begin
    s2_clear <= s1_clear;
    s2_iprod <= s1_iprod;
    s2_ic    <= i_c;
    s2_pd    <= (LIM_W+1)'(p_c) + (LIM_W+1)'(d_c);
    s2_pid   <= (LIM_W+2)'(p_c) + (LIM_W+2)'(i_c) + (LIM_W+2)'(d_c);
  end

  // stage 3: integral recurrence in the positional form
  logic signed [LIM_W-1:0] integral_term;
  logic signed [CMP_W-1:0] i_acc_full;
  logic signed [LIM_W-1:0] i_acc;
  logic                    s3_clear;
  logic signed [LIM_W-1:0] s3_inew;
  logic signed [LIM_W:0]   s3_pd;
  logic signed [LIM_W+1:0] s3_pid;

  assign i_acc_full = clamp_val(CMP_W'(integral_term) + CMP_W'(s2_iprod),
                                CMP_W'(thi), CMP_W'(tlo));
  assign i_acc      = i_acc_full[LIM_W-1:0];

  always_ff @(posedge clk) begin
    s3_clear <= s2_clear;
    s3_inew  <= i_acc;
    s3_pd    <= s2_pd;
    s3_pid   <= s2_pid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_term <= '0;
    end else if (s2_v) begin
      if (s2_clear) begin
        integral_term <= '0;
      end else if (cfg.form_select == FORM_POSITIONAL) begin
        integral_term <= i_acc;
      end else begin
        integral_term <= s2_ic;
      end
    end
  end

  // stage 4: drive accumulator, a recurrence in the incremental form
  logic signed [LIM_W-1:0] output_accumulator;
  logic signed [CMP_W-1:0] sum_pos, sum_inc;

  assign sum_pos = clamp_val(CMP_W'(s3_inew) + CMP_W'(s3_pd), CMP_W'(dhi), CMP_W'(dlo));
  assign sum_inc = clamp_val(CMP_W'(output_accumulator) + CMP_W'(s3_pid),
                             CMP_W'(dhi), CMP_W'(dlo));

  always_ff @(posedge clk) begin
    if (rst) begin
      output_accumulator <= '0;
    end else if (s3_v) begin
      if (s3_clear) begin
        output_accumulator <= '0;
      end else if (cfg.form_select == FORM_POSITIONAL) begin
        output_accumulator <= sum_pos[LIM_W-1:0];
      end else begin
        output_accumulator <= sum_inc[LIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  // truncate toward zero: negative values with a fraction round up by one
  logic round_up;
  assign round_up  = output_accumulator[LIM_W-1] && (output_accumulator[FRAC_BITS-1:0] != '0);
  assign out_push  = s4_v;
  assign out_drive = DRIVE_W'(output_accumulator[LIM_W-1:FRAC_BITS]
                   + {{(LIMIT_W-1){1'b0}}, round_up});

endmodule

// ===== rtl/cpid_checker.sv =====
// cpid_checker: port-level checks on the clamped pid controller
// bound to clamped_pid_controller; depends on cpid_pkg
module cpid_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                push,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [cpid_pkg::DRIVE_W-1:0] drive_value
);
  logic quiet;

  // no word taken in and nothing waiting on the result side
  assign quiet = empty && !(push && !full);

  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(drive_value)))
    else $error("waiting result changed or vanished");

  // no result may surface after a quiet history: pipe plus queues have drained by then
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (quiet && $past(quiet, 1) && $past(quiet, 2) && $past(quiet, 3)
      && $past(quiet, 4) && $past(quiet, 5)) |=> empty)
    else $error("result appeared with no word in flight");

endmodule

bind clamped_pid_controller cpid_checker u_checker (.*);

// ===== dv/clamped_pid_controller_test.sv =====
// clamped_pid_controller_test: self-checking bench for the clamped pid controller
// predicts each drive word from its own copy of gains, limits and error history
// depends on cpid_pkg and the clamped_pid_controller rtl
module clamped_pid_controller_test;
  import cpid_pkg::*;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int STALL_MAX  = 5000;
  localparam int RAND_WORDS = 192;

  typedef struct {
    logic                       req;
    logic signed [SAMPLE_W-1:0] tgt;
    logic signed [SAMPLE_W-1:0] meas;
  } pid_req_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic                          req_type = REQ_STEP;
  logic signed [SAMPLE_W-1:0]    target_value = '0;
  logic signed [SAMPLE_W-1:0]    measured_value = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [DRIVE_W-1:0]     drive_value;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  pid_req_t                  pending_reqs[$];
  logic signed [DRIVE_W-1:0] drive_expected_q[$];
  pid_req_t                  send_word;
  cfg_t                      pid_cfg;
  longint                    last_err, older_err, integ, drive_acc;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;
  int                        mismatch_count = 0;
  int                        stall_cycles = 0;

  clamped_pid_controller #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .FRAC_BITS   (FRAC_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .target_value  (target_value),
    .measured_value(measured_value),
    .empty         (empty),
    .pop           (pop),
    .drive_value   (drive_value),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint clip(longint x, longint hi, longint lo);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // steps the controller copy by one request and returns the drive word
  function automatic logic signed [DRIVE_W-1:0] next_drive(logic req,
      logic signed [SAMPLE_W-1:0] tgt, logic signed [SAMPLE_W-1:0] meas);
    longint one, kp, ki, kd, thi, tlo, dhi, dlo, err, p, d, total;
    one = longint'(1) << FRAC_BITS;
    kp  = longint'($signed(pid_cfg.kp_gain));
    ki  = longint'($signed(pid_cfg.ki_gain));
    kd  = longint'($signed(pid_cfg.kd_gain));
    thi = longint'($signed(pid_cfg.term_upper)) * one;
    tlo = longint'($signed(pid_cfg.term_lower)) * one;
    dhi = longint'($signed(pid_cfg.drive_upper)) * one;
    dlo = longint'($signed(pid_cfg.drive_lower)) * one;
    if (req == REQ_CLEAR) begin
      last_err  = 0;
      older_err = 0;
      integ     = 0;
      drive_acc = 0;
      return '0;
    end
    err = longint'(tgt) - longint'(meas);
    if (pid_cfg.form_select == FORM_POSITIONAL) begin
      p     = clip(kp * err, thi, tlo);
      integ = clip(integ + ki * err, thi, tlo);
      d     = clip(kd * (err - last_err), thi, tlo);
      total = clip(p + integ + d, dhi, dlo);
    end else begin
      // second difference feeds the d term
      p         = clip(kp * (err - last_err), thi, tlo);
      integ     = clip(ki * err, thi, tlo);
      d         = clip(kd * (err - 2 * last_err + older_err), thi, tlo);
      total     = clip(drive_acc + p + integ + d, dhi, dlo);
      older_err = last_err;
    end
    drive_acc = total;
    last_err  = err;
    // longint division truncates toward zero
    return DRIVE_W'(total / one);
  endfunction

  task automatic report_mismatch(string what, logic signed [DRIVE_W-1:0] got,
      logic signed [DRIVE_W-1:0] want);
    $display("mismatch at %0t: %s: drive_value got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_KP_GAIN:     pid_cfg.kp_gain = data;
      REG_KI_GAIN:     pid_cfg.ki_gain = data;
      REG_KD_GAIN:     pid_cfg.kd_gain = data;
      REG_FORM_SELECT: pid_cfg.form_select = data[0];
      REG_TERM_UPPER:  pid_cfg.term_upper = data[LIMIT_W-1:0];
      REG_TERM_LOWER:  pid_cfg.term_lower = data[LIMIT_W-1:0];
      REG_DRIVE_UPPER: pid_cfg.drive_upper = data[LIMIT_W-1:0];
      REG_DRIVE_LOWER: pid_cfg.drive_lower = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(REG_KP_GAIN, c.kp_gain);
    write_reg(REG_KI_GAIN, c.ki_gain);
    write_reg(REG_KD_GAIN, c.kd_gain);
    write_reg(REG_FORM_SELECT, 32'(c.form_select));
    write_reg(REG_TERM_UPPER, 32'($signed(c.term_upper)));
    write_reg(REG_TERM_LOWER, 32'($signed(c.term_lower)));
    write_reg(REG_DRIVE_UPPER, 32'($signed(c.drive_upper)));
    write_reg(REG_DRIVE_LOWER, 32'($signed(c.drive_lower)));
    @(negedge clk);
  endtask

  // waits until every queued word is sent and every drive word is back
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || push || drive_expected_q.size() != 0);
  endtask

  task automatic queue_req(logic req, logic signed [SAMPLE_W-1:0] tgt,
      logic signed [SAMPLE_W-1:0] meas);
    pid_req_t r;
    r.req  = req;
    r.tgt  = tgt;
    r.meas = meas;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'(int'($urandom_range(8192)) - 4096);
      default: return 32'(int'($urandom_range(524288)) - 262144);
    endcase
  endfunction

  function automatic void pick_limits(output logic signed [LIMIT_W-1:0] hi,
      output logic signed [LIMIT_W-1:0] lo);
    case ($urandom_range(9))
      0: begin
        hi = LIMIT_MAX;
        lo = LIMIT_MIN;
      end
      1: begin
        // inverted pair
        hi = -LIMIT_W'($urandom_range(2000));
        lo = LIMIT_W'($urandom_range(2000));
      end
      2: begin
        hi = LIMIT_W'($urandom());
        lo = LIMIT_W'($urandom());
      end
      default: begin
        hi = LIMIT_W'($urandom_range(32767));
        lo = -LIMIT_W'($urandom_range(32768));
      end
    endcase
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 9;
        recv_idle_pct = 87;
      end
      1: begin
        send_idle_pct = 87;
        recv_idle_pct = 9;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        drive_expected_q.push_back(next_drive(req_type, target_value, measured_value));
      end
      if (!(push && full)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          send_word = pending_reqs.pop_front();
          push           <= 1'b1;
          req_type       <= send_word.req;
          target_value   <= send_word.tgt;
          measured_value <= send_word.meas;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // drive word monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (drive_expected_q.size() == 0) begin
          report_mismatch("word with nothing expected", drive_value, '0);
        end else if (drive_value !== drive_expected_q[0]) begin
          report_mismatch("wrong drive", drive_value, drive_expected_q.pop_front());
        end else begin
          void'(drive_expected_q.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || cfg_write || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    cfg_t     plan;
    pid_req_t r;
    pid_cfg = '0;
    pid_cfg.term_upper  = LIMIT_MAX;
    pid_cfg.term_lower  = LIMIT_MIN;
    pid_cfg.drive_upper = LIMIT_MAX;
    pid_cfg.drive_lower = LIMIT_MIN;
    last_err  = 0;
    older_err = 0;
    integ     = 0;
    drive_acc = 0;
    set_idling(0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // gains still at reset value
    queue_req(REQ_STEP, 16'sd1000, -16'sd1000);
    drain();

    plan = pid_cfg;
    plan.kp_gain     = 32'h0001_0000;
    plan.ki_gain     = 32'h0000_8000;
    plan.kd_gain     = 32'h0000_4000;
    plan.form_select = FORM_POSITIONAL;
    load_cfg(plan);
    queue_req(REQ_STEP, LIMIT_MAX, LIMIT_MIN);
    queue_req(REQ_STEP, LIMIT_MIN, LIMIT_MAX);
    queue_req(REQ_STEP, 16'sd0, 16'sd0);
    queue_req(REQ_STEP, 16'sd3, 16'sd0);
    queue_req(REQ_STEP, -16'sd3, 16'sd0);
    queue_req(REQ_CLEAR, 16'sd77, -16'sd5);
    queue_req(REQ_STEP, -16'sd1, 16'sd0);
    queue_req(REQ_STEP, 16'sd100, 16'sd40);
    drain();

    // incremental form with the term limits inverted
    plan.kp_gain     = -32'sh0001_8000;
    plan.ki_gain     = 32'h7fff_ffff;
    plan.kd_gain     = 32'h8000_0000;
    plan.form_select = FORM_INCREMENTAL;
    plan.term_upper  = -16'sd100;
    plan.term_lower  = 16'sd100;
    plan.drive_upper = 16'sd1000;
    plan.drive_lower = -16'sd1000;
    load_cfg(plan);
    queue_req(REQ_STEP, 16'sd10, 16'sd0);
    queue_req(REQ_STEP, -16'sd10, 16'sd0);
    queue_req(REQ_STEP, 16'sd0, 16'sd5);
    queue_req(REQ_STEP, LIMIT_MAX, LIMIT_MIN);
    queue_req(REQ_CLEAR, LIMIT_MIN, LIMIT_MAX);
    queue_req(REQ_STEP, 16'sd5, 16'sd5);
    drain();

    // back to positional with no clear first, drive limits inverted
    plan.kp_gain     = 32'h0000_0003;
    plan.ki_gain     = -32'sh0001_0000;
    plan.kd_gain     = 32'h0002_0000;
    plan.form_select = FORM_POSITIONAL;
    plan.term_upper  = LIMIT_MAX;
    plan.term_lower  = LIMIT_MIN;
    plan.drive_upper = -16'sd5;
    plan.drive_lower = 16'sd5;
    load_cfg(plan);
    queue_req(REQ_STEP, 16'sd1, 16'sd0);
    queue_req(REQ_STEP, -16'sd200, 16'sd0);
    queue_req(REQ_STEP, 16'sd7, 16'sd7);
    queue_req(REQ_STEP, LIMIT_MIN, LIMIT_MAX);
    queue_req(REQ_CLEAR, -16'sd1, -16'sd1);
    queue_req(REQ_STEP, 16'sd50, -16'sd20);
    drain();

    plan.form_select = FORM_INCREMENTAL;
    plan.drive_upper = LIMIT_MAX;
    plan.drive_lower = LIMIT_MIN;
    load_cfg(plan);
    queue_req(REQ_STEP, 16'sd300, 16'sd0);
    queue_req(REQ_STEP, -16'sd300, 16'sd100);
    queue_req(REQ_STEP, 16'sd0, 16'sd0);
    drain();

    // random phases; state carries over between them unless a clear comes
    for (int ph = 0; ph < 9; ph++) begin
      set_idling(ph / 3);
      plan.kp_gain     = pick_gain();
      plan.ki_gain     = pick_gain();
      plan.kd_gain     = pick_gain();
      plan.form_select = 1'($urandom_range(1));
      pick_limits(plan.term_upper, plan.term_lower);
      pick_limits(plan.drive_upper, plan.drive_lower);
      load_cfg(plan);
      for (int n = 0; n < RAND_WORDS; n++) begin
        r.req = ($urandom_range(99) < 4) ? REQ_CLEAR : REQ_STEP;
        r.tgt = SAMPLE_W'($urandom());
        // mostly small errors so the terms do not all saturate
        if ($urandom_range(2) == 0) r.meas = SAMPLE_W'($urandom());
        else r.meas = r.tgt + SAMPLE_W'($urandom_range(400)) - 16'sd200;
        pending_reqs.push_back(r);
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && drive_expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
